[rtl/ttcw_pkg.sv]
package ttcw_pkg;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 32;
    localparam int TAB_STOP    = 8;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COLS_W      = COL_W + 1;
    localparam int ROWS_W      = ROW_W + 1;
    localparam int TAB_W       = $clog2(TAB_STOP);
    localparam int CNT_W       = TAB_W + 1;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [COLS_W-1:0] COLS_MIN   = COLS_W'(16);
    localparam logic [COLS_W-1:0] COLS_MAX   = COLS_W'(MAX_COLS);
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
    localparam logic [ROWS_W-1:0] ROWS_MIN   = ROWS_W'(4);
    localparam logic [ROWS_W-1:0] ROWS_MAX   = ROWS_W'(MAX_ROWS);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(25);

    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [KIND_W-1:0] EV_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] EV_MOVE  = 2'd1;
    localparam logic [KIND_W-1:0] EV_BELL  = 2'd2;
    localparam logic [KIND_W-1:0] EV_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

    typedef enum logic [2:0] {
        STEP_HOLD,
        STEP_ADV,
        STEP_NL,
        STEP_CR,
        STEP_BACK
    } step_op_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cursor_t;

    typedef struct packed {
        cursor_t          cur;
        logic [ROW_W-1:0] top;
        logic             scrolled;
    } step_res_t;

endpackage

[rtl/text_terminal_char_writer_top.sv]
// Each accepted item is registered, then decoded, and gives its result from a put, command
// or read state; a tab gives one result per space, up to eight in all, one per cycle while
// the output is not stalled and no scroll comes between. A new item is taken only once the
// last is through, as the sequencer and the single store write port allow; a scroll adds a
// clear of the new bottom row. Reset, and any configuration write, starts a clearing pass of
// the screen store during which no item is accepted; cursor and scroll offset return to zero.
module text_terminal_char_writer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ttcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [ttcw_pkg::CHAR_W-1:0]       char_in,
    input  logic [ttcw_pkg::ROW_W-1:0]        read_row,
    input  logic [ttcw_pkg::COL_W-1:0]        read_col,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ttcw_pkg::KIND_W-1:0]       event_kind,
    output logic [ttcw_pkg::ROW_W-1:0]        cell_row,
    output logic [ttcw_pkg::COL_W-1:0]        cell_col,
    output logic [ttcw_pkg::CHAR_W-1:0]       cell_char,
    output logic                              scrolled,
    output logic [ttcw_pkg::ROW_W-1:0]        cursor_row_now,
    output logic [ttcw_pkg::COL_W-1:0]        cursor_col_now,
    output logic                              last
);
    import ttcw_pkg::*;

    typedef enum logic [2:0] {
        S_CLRALL,
        S_IDLE,
        S_EXEC,
        S_CMD,
        S_PUT,
        S_ROWCLR,
        S_READ
    } state_t;

    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic [ROW_W-1:0]   rr_reg, rr_next;
    logic [COL_W-1:0]   rc_reg, rc_next;
    cursor_t            cur_reg, cur_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [COLS_W-1:0]  cols_reg, cols_next;
    logic [ROWS_W-1:0]  rows_reg, rows_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;

    logic               ov_reg, ov_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [ROW_W-1:0]   crow_reg, crow_next;
    logic [COL_W-1:0]   ccol_reg, ccol_next;
    logic [CHAR_W-1:0]  cchar_reg, cchar_next;
    logic               scr_reg, scr_next;
    logic [ROW_W-1:0]   nrow_reg, nrow_next;
    logic [COL_W-1:0]   ncol_reg, ncol_next;
    logic               last_reg, last_next;

    step_op_t           step_op;
    step_res_t          step_res;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CHAR_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]   cur_phys;
    logic               out_free;
    logic               rd_inside;

    ttcw_step_unit u_step (
        .op   (step_op),
        .cur  (cur_reg),
        .top  (top_reg),
        .cols (cols_reg),
        .rows (rows_reg),
        .res  (step_res)
    );

    ttcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Logical rows map onto physical rows through a circular offset.
    assign cur_phys  = top_reg + cur_reg.row;
    assign ram_raddr = {top_reg + rr_reg, rc_reg};
    assign rd_inside = ({1'b0, rr_reg} < rows_reg) && ({1'b0, rc_reg} < cols_reg);
    assign out_free  = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        rr_next    = rr_reg;
        rc_next    = rc_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg;
        kind_next  = kind_reg;
        crow_next  = crow_reg;
        ccol_next  = ccol_reg;
        cchar_next = cchar_reg;
        scr_next   = scr_reg;
        nrow_next  = nrow_reg;
        ncol_next  = ncol_reg;
        last_next  = last_reg;
        step_op    = STEP_HOLD;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = CH_SPACE;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLRALL:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    ch_next    = char_in;
                    rr_next    = read_row;
                    rc_next    = read_col;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_READ)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    case (ch_reg) inside
                        CH_CR, CH_LF, CH_BEL, CH_BS, CH_DEL:
                        begin
                            state_next = S_CMD;
                        end
                        CH_TAB:
                        begin
                            cnt_next   = CNT_W'(TAB_STOP) - {1'b0, cur_reg.col[TAB_W-1:0]};
                            ch_next    = CH_SPACE;
                            state_next = S_PUT;
                        end
                        default:
                        begin
                            cnt_next   = CNT_W'(1);
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_CMD:
            begin
                case (ch_reg) inside
                    CH_CR:          step_op = STEP_CR;
                    CH_LF:          step_op = STEP_NL;
                    CH_BS, CH_DEL:  step_op = STEP_BACK;
                    default:        step_op = STEP_HOLD;
                endcase
                if (out_free)
                begin
                    cur_next   = step_res.cur;
                    top_next   = step_res.top;
                    ov_next    = 1'b1;
                    kind_next  = (ch_reg == CH_BEL) ? EV_BELL : EV_MOVE;
                    crow_next  = '0;
                    ccol_next  = '0;
                    cchar_next = '0;
                    scr_next   = step_res.scrolled;
                    nrow_next  = step_res.cur.row;
                    ncol_next  = step_res.cur.col;
                    last_next  = 1'b1;
                    cnt_next   = '0;
                    clr_next   = '0;
                    state_next = step_res.scrolled ? S_ROWCLR : S_IDLE;
                end
            end
            S_PUT:
            begin
                step_op = STEP_ADV;
                if (out_free)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = {cur_phys, cur_reg.col};
                    ram_wdata  = ch_reg;
                    cur_next   = step_res.cur;
                    top_next   = step_res.top;
                    ov_next    = 1'b1;
                    kind_next  = EV_WRITE;
                    crow_next  = cur_reg.row;
                    ccol_next  = cur_reg.col;
                    cchar_next = ch_reg;
                    scr_next   = step_res.scrolled;
                    nrow_next  = step_res.cur.row;
                    ncol_next  = step_res.cur.col;
                    last_next  = (cnt_reg == CNT_W'(1));
                    cnt_next   = cnt_reg - CNT_W'(1);
                    clr_next   = '0;
                    if (step_res.scrolled)
                    begin
                        state_next = S_ROWCLR;
                    end
                    else if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ROWCLR:
            begin
                // The cursor already sits on the new bottom row, so its physical
                // row is the one to blank.
                ram_we    = 1'b1;
                ram_waddr = {cur_phys, clr_reg[COL_W-1:0]};
                clr_next  = clr_reg + ADDR_W'(1);
                if (&clr_reg[COL_W-1:0])
                begin
                    state_next = (cnt_reg == '0) ? S_IDLE : S_PUT;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    kind_next  = EV_READ;
                    crow_next  = rr_reg;
                    ccol_next  = rc_reg;
                    cchar_next = rd_inside ? ram_rdata : CH_SPACE;
                    scr_next   = 1'b0;
                    nrow_next  = cur_reg.row;
                    ncol_next  = cur_reg.col;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A write saturates the value (rows: low six bits), homes cursor and clears screen.
        if (cfg_we)
        begin
            if (cfg_index == REG_COLS)
            begin
                if (cfg_data < COLS_MIN)
                begin
                    cols_next = COLS_MIN;
                end
                else if (cfg_data > COLS_MAX)
                begin
                    cols_next = COLS_MAX;
                end
                else
                begin
                    cols_next = cfg_data[COLS_W-1:0];
                end
            end
            else
            begin
                if (cfg_data[ROWS_W-1:0] < ROWS_MIN)
                begin
                    rows_next = ROWS_MIN;
                end
                else if (cfg_data[ROWS_W-1:0] > ROWS_MAX)
                begin
                    rows_next = ROWS_MAX;
                end
                else
                begin
                    rows_next = cfg_data[ROWS_W-1:0];
                end
            end
            cur_next   = '0;
            top_next   = '0;
            clr_next   = '0;
            state_next = S_CLRALL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLRALL;
            op_reg    <= OP_PUT;
            ch_reg    <= '0;
            rr_reg    <= '0;
            rc_reg    <= '0;
            cur_reg   <= '0;
            top_reg   <= '0;
            cols_reg  <= COLS_RESET;
            rows_reg  <= ROWS_RESET;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            kind_reg  <= EV_WRITE;
            crow_reg  <= '0;
            ccol_reg  <= '0;
            cchar_reg <= '0;
            scr_reg   <= 1'b0;
            nrow_reg  <= '0;
            ncol_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ch_reg    <= ch_next;
            rr_reg    <= rr_next;
            rc_reg    <= rc_next;
            cur_reg   <= cur_next;
            top_reg   <= top_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            kind_reg  <= kind_next;
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
            cchar_reg <= cchar_next;
            scr_reg   <= scr_next;
            nrow_reg  <= nrow_next;
            ncol_reg  <= ncol_next;
            last_reg  <= last_next;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = ov_reg;
    assign event_kind     = kind_reg;
    assign cell_row       = crow_reg;
    assign cell_col       = ccol_reg;
    assign cell_char      = cchar_reg;
    assign scrolled       = scr_reg;
    assign cursor_row_now = nrow_reg;
    assign cursor_col_now = ncol_reg;
    assign last           = last_reg;

endmodule

[rtl/ttcw_ram.sv]
module ttcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ttcw_step_unit.sv]
module ttcw_step_unit (
    input  ttcw_pkg::step_op_t               op,
    input  ttcw_pkg::cursor_t                cur,
    input  logic [ttcw_pkg::ROW_W-1:0]       top,
    input  logic [ttcw_pkg::COLS_W-1:0]      cols,
    input  logic [ttcw_pkg::ROWS_W-1:0]      rows,
    output ttcw_pkg::step_res_t              res
);
    import ttcw_pkg::*;

    logic [COLS_W-1:0] col_inc;
    logic [ROWS_W-1:0] row_inc;
    logic [COLS_W-1:0] cols_m1;
    logic [ROWS_W-1:0] rows_m1;
    step_res_t         nl;

    assign col_inc = {1'b0, cur.col} + COLS_W'(1);
    assign row_inc = {1'b0, cur.row} + ROWS_W'(1);
    assign cols_m1 = cols - COLS_W'(1);
    assign rows_m1 = rows - ROWS_W'(1);

    // New line: column 0 of the next row, scrolling past the bottom row.
    always_comb
    begin
        nl          = '0;
        nl.cur.col  = '0;
        nl.top      = top;
        if (row_inc >= rows)
        begin
            nl.scrolled = 1'b1;
            nl.top      = top + ROW_W'(1);
            nl.cur.row  = rows_m1[ROW_W-1:0];
        end
        else
        begin
            nl.scrolled = 1'b0;
            nl.cur.row  = row_inc[ROW_W-1:0];
        end
    end

    always_comb
    begin
        res          = '0;
        res.cur      = cur;
        res.top      = top;
        res.scrolled = 1'b0;
        case (op)
            STEP_ADV:
            begin
                if (col_inc >= cols)
                begin
                    res = nl;
                end
                else
                begin
                    res.cur.col = col_inc[COL_W-1:0];
                end
            end
            STEP_NL:
            begin
                res = nl;
            end
            STEP_CR:
            begin
                res.cur.col = '0;
            end
            STEP_BACK:
            begin
                if (cur.col == '0)
                begin
                    res.cur.col = cols_m1[COL_W-1:0];
                    if (cur.row != '0)
                    begin
                        res.cur.row = cur.row - ROW_W'(1);
                    end
                end
                else
                begin
                    res.cur.col = cur.col - COL_W'(1);
                end
            end
            default:
            begin
                res.cur = cur;
            end
        endcase
    end

endmodule
